### rtl/rpbi_pkg.sv
package rpbi_pkg;

    localparam int NUM_CHANNELS = 14;

    localparam int CMD_W     = 2;
    localparam int RSSI_W    = 8;
    localparam int CHAN_W    = 4;
    localparam int ON_W      = 8;
    localparam int OFF_W     = 10;
    localparam int DECAY_W   = 6;
    localparam int DCOUNT_W  = 7;
    localparam int BLINK_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CMD_W-1:0] CMD_PACKET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCAN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_MAX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEPS = 2'd3;

    localparam logic [ON_W-1:0]          ON_TIME_RST     = 8'd1;
    localparam logic [OFF_W-1:0]         OFF_MAX_RST     = 10'd500;
    localparam logic signed [RSSI_W-1:0] NEAR_THR_RST    = -8'sd60;
    localparam logic [DECAY_W-1:0]       DECAY_STEPS_RST = 6'd40;

    localparam logic signed [RSSI_W-1:0] PEAK_FLOOR  = -8'sd90;
    localparam logic signed [RSSI_W-1:0] LADDER_BASE = -8'sd65;

    localparam logic [CHAN_W-1:0] HOP_FIRST = 4'd1;
    localparam logic [CHAN_W-1:0] HOP_LAST  = CHAN_W'(NUM_CHANNELS);

    typedef struct packed {
        logic                     led_on;
        logic [CHAN_W-1:0]        tune_channel;
        logic signed [RSSI_W-1:0] peak_level;
        logic [CHAN_W-1:0]        peak_chan;
        logic [OFF_W-1:0]         off_ticks;
    } rpbi_result_t;

    // extra off time for a peak above the ladder base
    function automatic logic [6:0] ladder_extra(input logic signed [RSSI_W-1:0] p);
        logic [6:0] e;
        begin
            if (p > -8'sd30)
                e = 7'd0;
            else if (p > -8'sd35)
                e = 7'd10;
            else if (p > -8'sd40)
                e = 7'd30;
            else if (p > -8'sd45)
                e = 7'd50;
            else if (p > -8'sd50)
                e = 7'd70;
            else if (p > -8'sd60)
                e = 7'd80;
            else
                e = 7'd100;
            return e;
        end
    endfunction

endpackage

### rtl/rpbi_core.sv
module rpbi_core
    import rpbi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [RSSI_W-1:0] rssi,
    input  logic [CHAN_W-1:0]        rx_channel,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_idx,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    output rpbi_result_t             result
);

    logic [ON_W-1:0]          on_time_reg;
    logic [OFF_W-1:0]         off_max_reg;
    logic signed [RSSI_W-1:0] near_thr_reg;
    logic [DECAY_W-1:0]       decay_steps_reg;

    logic signed [RSSI_W-1:0] peak_rssi_reg, peak_rssi_next;
    logic [CHAN_W-1:0]        peak_chan_reg, peak_chan_next;
    logic [OFF_W-1:0]         off_time_reg, off_time_next;
    logic [BLINK_W-1:0]       blink_reg, blink_next;
    logic                     led_reg, led_next;
    logic [CHAN_W-1:0]        hop_reg, hop_next;
    logic [DCOUNT_W-1:0]      decay_reg, decay_next;

    logic [BLINK_W-1:0]       blink_inc;
    logic [DCOUNT_W-1:0]      decay_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_time_reg     <= ON_TIME_RST;
            off_max_reg     <= OFF_MAX_RST;
            near_thr_reg    <= NEAR_THR_RST;
            decay_steps_reg <= DECAY_STEPS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_ON_TIME:     on_time_reg     <= cfg_wdata[ON_W-1:0];
                CFG_OFF_MAX:     off_max_reg     <= cfg_wdata[OFF_W-1:0];
                CFG_NEAR_THR:    near_thr_reg    <= signed'(cfg_wdata[RSSI_W-1:0]);
                CFG_DECAY_STEPS: decay_steps_reg <= cfg_wdata[DECAY_W-1:0];
                default:         ;
            endcase
        end
    end

    assign blink_inc = blink_reg + BLINK_W'(1);
    assign decay_inc = decay_reg + DCOUNT_W'(1);

    always_comb
    begin
        peak_rssi_next = peak_rssi_reg;
        peak_chan_next = peak_chan_reg;
        off_time_next  = off_time_reg;
        blink_next     = blink_reg;
        led_next       = led_reg;
        hop_next       = hop_reg;
        decay_next     = decay_reg;
        case (cmd)
            CMD_PACKET:
            begin
                if (rssi > near_thr_reg && rssi > peak_rssi_reg)
                begin
                    peak_rssi_next = rssi;
                    peak_chan_next = rx_channel;
                end
            end
            CMD_SCAN:
            begin
                hop_next = (hop_reg == HOP_LAST) ? HOP_FIRST : hop_reg + CHAN_W'(1);
                if (peak_rssi_reg > LADDER_BASE)
                    off_time_next = OFF_W'(on_time_reg) + OFF_W'(ladder_extra(peak_rssi_reg));
                decay_next = decay_inc;
                if (decay_inc > DCOUNT_W'(decay_steps_reg))
                begin
                    peak_rssi_next = PEAK_FLOOR;
                    peak_chan_next = '0;
                    off_time_next  = off_max_reg;
                    decay_next     = '0;
                end
            end
            CMD_TICK:
            begin
                blink_next = blink_inc;
                if (blink_inc >= BLINK_W'(on_time_reg))
                    led_next = 1'b0;
                if (blink_inc > BLINK_W'(off_time_reg))
                begin
                    led_next   = 1'b1;
                    blink_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_rssi_reg <= PEAK_FLOOR;
            peak_chan_reg <= '0;
            off_time_reg  <= OFF_MAX_RST;
            blink_reg     <= '0;
            led_reg       <= 1'b0;
            hop_reg       <= HOP_FIRST;
            decay_reg     <= '0;
        end
        else if (step)
        begin
            peak_rssi_reg <= peak_rssi_next;
            peak_chan_reg <= peak_chan_next;
            off_time_reg  <= off_time_next;
            blink_reg     <= blink_next;
            led_reg       <= led_next;
            hop_reg       <= hop_next;
            decay_reg     <= decay_next;
        end
    end

    assign result.led_on       = led_next;
    assign result.tune_channel = hop_next;
    assign result.peak_level   = peak_rssi_next;
    assign result.peak_chan    = peak_chan_next;
    assign result.off_ticks    = off_time_next;

endmodule

### rtl/rssi_peak_blink_indicator_top.sv
// Signal strength activity indicator driving an LED.
// Input channel (in_valid/in_ready): one event per transfer, cmd selects a
// packet (rssi, rx_channel), a scan step or a blink tick; cmd 3 changes nothing.
// Output channel (out_valid/out_ready): exactly one result per event, showing
// LED level, tune channel, held peak, its channel and the current off time.
// The result is registered and presented in the cycle after the input transfer.
// Throughput: one event per cycle while the receiver accepts results; the state update is
// combinational logic between the state registers and the output register.
// When the receiver stalls, the output register holds its result and the next
// event is taken in the same cycle the held result is transferred.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 on_time, 1 off_max, 2 near_threshold, 3 decay_steps. Write only
// while idle; a new off_max takes effect at the next decay.
// Reset: peak -90, peak channel 0, off time 500, LED off, hop channel 1,
// registers to on_time 1, off_max 500, near_threshold -60, decay_steps 40.
module rssi_peak_blink_indicator_top
    import rpbi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [RSSI_W-1:0] rssi,
    input  logic [CHAN_W-1:0]        rx_channel,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     led_on,
    output logic [CHAN_W-1:0]        tune_channel,
    output logic signed [RSSI_W-1:0] peak_level,
    output logic [CHAN_W-1:0]        peak_chan,
    output logic [OFF_W-1:0]         off_ticks,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    logic         step;
    logic         out_valid_reg;
    rpbi_result_t result;
    rpbi_result_t res_reg;

    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    rpbi_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cmd        (cmd),
        .rssi       (rssi),
        .rx_channel (rx_channel),
        .cfg_we     (cfg_valid),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= result;
    end

    assign out_valid    = out_valid_reg;
    assign led_on       = res_reg.led_on;
    assign tune_channel = res_reg.tune_channel;
    assign peak_level   = res_reg.peak_level;
    assign peak_chan    = res_reg.peak_chan;
    assign off_ticks    = res_reg.off_ticks;

endmodule

### verif/tb_rssi_peak_blink_indicator_top.sv
`timescale 1ns / 100ps

module tb_rssi_peak_blink_indicator_top;
    import rpbi_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         cmd = CMD_PACKET;
    logic signed [RSSI_W-1:0] rssi = '0;
    logic [CHAN_W-1:0]        rx_channel = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     led_on;
    logic [CHAN_W-1:0]        tune_channel;
    logic signed [RSSI_W-1:0] peak_level;
    logic [CHAN_W-1:0]        peak_chan;
    logic [OFF_W-1:0]         off_ticks;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_ON_TIME;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    // indicator registers and state as predicted
    logic [ON_W-1:0]          on_time_m;
    logic [OFF_W-1:0]         off_max_m;
    logic signed [RSSI_W-1:0] near_thr_m;
    logic [DECAY_W-1:0]       decay_steps_m;
    logic signed [RSSI_W-1:0] peak_m;
    logic [CHAN_W-1:0]        peak_ch_m;
    logic [OFF_W-1:0]         off_time_m;
    logic [BLINK_W-1:0]       blink_m;
    logic                     led_m;
    logic [CHAN_W-1:0]        hop_m;
    logic [DCOUNT_W-1:0]      decay_cnt_m;

    rpbi_result_t status_q[$];
    rpbi_result_t want;

    logic no_idle = 1'b0;
    int   mismatches = 0;
    int   results_seen = 0;
    int   blink_restarts = 0;
    int   settings_used = 0;
    int   events_by_cmd[4] = '{0, 0, 0, 0};
    int   idle_cycles = 0;

    rssi_peak_blink_indicator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .rssi         (rssi),
        .rx_channel   (rx_channel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .led_on       (led_on),
        .tune_channel (tune_channel),
        .peak_level   (peak_level),
        .peak_chan    (peak_chan),
        .off_ticks    (off_ticks),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int extra_off_time(input logic signed [RSSI_W-1:0] p);
        int v;
        v = int'(p);
        if (v > -30)
            return 0;
        if (v > -35)
            return 10;
        if (v > -40)
            return 30;
        if (v > -45)
            return 50;
        if (v > -50)
            return 70;
        if (v > -60)
            return 80;
        return 100;
    endfunction

    task automatic update_indicator(input logic [CMD_W-1:0] c,
                                    input logic signed [RSSI_W-1:0] r,
                                    input logic [CHAN_W-1:0] ch);
        rpbi_result_t st;
        events_by_cmd[c]++;
        case (c)
            CMD_PACKET:
            begin
                if (r > near_thr_m && r > peak_m)
                begin
                    peak_m    = r;
                    peak_ch_m = ch;
                end
            end
            CMD_SCAN:
            begin
                hop_m = CHAN_W'((int'(hop_m) % NUM_CHANNELS) + 1);
                if (peak_m > LADDER_BASE)
                    off_time_m = OFF_W'(int'(on_time_m) + extra_off_time(peak_m));
                decay_cnt_m = decay_cnt_m + DCOUNT_W'(1);
                if (decay_cnt_m > DCOUNT_W'(decay_steps_m))
                begin
                    peak_m      = PEAK_FLOOR;
                    peak_ch_m   = '0;
                    off_time_m  = off_max_m;
                    decay_cnt_m = '0;
                end
            end
            CMD_TICK:
            begin
                blink_m = blink_m + BLINK_W'(1);
                if (blink_m >= BLINK_W'(on_time_m))
                    led_m = 1'b0;
                if (blink_m > BLINK_W'(off_time_m))
                begin
                    led_m   = 1'b1;
                    blink_m = '0;
                    blink_restarts++;
                end
            end
            default: ;
        endcase
        st.led_on       = led_m;
        st.tune_channel = hop_m;
        st.peak_level   = peak_m;
        st.peak_chan    = peak_ch_m;
        st.off_ticks    = off_time_m;
        status_q.push_back(st);
    endtask

    // valid is left high after a transfer so back-to-back events need no toggle
    task automatic send_event(input logic [CMD_W-1:0] c,
                              input logic signed [RSSI_W-1:0] r,
                              input logic [CHAN_W-1:0] ch);
        if (!no_idle && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 7);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        rssi       <= r;
        rx_channel <= ch;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        update_indicator(c, r, ch);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ON_TIME:     on_time_m     = data[ON_W-1:0];
            CFG_OFF_MAX:     off_max_m     = data[OFF_W-1:0];
            CFG_NEAR_THR:    near_thr_m    = signed'(data[RSSI_W-1:0]);
            CFG_DECAY_STEPS: decay_steps_m = data[DECAY_W-1:0];
            default: ;
        endcase
    endtask

    // unused upper data bits are filled at random
    task automatic apply_settings(input logic [ON_W-1:0] on_t,
                                  input logic [OFF_W-1:0] off_m,
                                  input logic signed [RSSI_W-1:0] near_t,
                                  input logic [DECAY_W-1:0] decay_s);
        wait_drain();
        write_reg(CFG_ON_TIME, {2'($urandom), on_t});
        write_reg(CFG_OFF_MAX, off_m);
        write_reg(CFG_NEAR_THR, {2'($urandom), near_t});
        write_reg(CFG_DECAY_STEPS, {4'($urandom), decay_s});
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic test_reset_defaults();
        send_event(CMD_SCAN, 8'sd0, 4'd0);
        send_event(CMD_TICK, 8'sd0, 4'd0);
        send_event(CMD_UNUSED, 8'sd127, 4'd15);
        send_event(CMD_PACKET, -8'sd60, 4'd3);
        send_event(CMD_PACKET, 8'sh80, 4'd0);
    endtask

    task automatic test_ladder();
        send_event(CMD_PACKET, -8'sd62, 4'd1);
        send_event(CMD_SCAN, 8'sd0, 4'd0);
        send_event(CMD_PACKET, -8'sd47, 4'd6);
        send_event(CMD_SCAN, 8'sd0, 4'd0);
        send_event(CMD_PACKET, -8'sd37, 4'd11);
        send_event(CMD_SCAN, 8'sd0, 4'd0);
        send_event(CMD_PACKET, -8'sd32, 4'd14);
        send_event(CMD_SCAN, 8'sd0, 4'd0);
        send_event(CMD_PACKET, 8'sd127, 4'd15);
        send_event(CMD_SCAN, 8'sd0, 4'd0);
    endtask

    task automatic test_blink();
        send_event(CMD_TICK, 8'sd0, 4'd0);
        send_event(CMD_TICK, 8'sd0, 4'd0);
        send_event(CMD_TICK, 8'sd0, 4'd0);
    endtask

    // zero on_time, off_max and decay_steps, then an off_max change seen only at the next decay
    task automatic test_zero_and_off_max();
        apply_settings(8'd0, 10'd0, 8'sd127, 6'd0);
        send_event(CMD_TICK, 8'sd0, 4'd0);
        send_event(CMD_SCAN, 8'sd0, 4'd0);
        send_event(CMD_PACKET, 8'sd127, 4'd5);
        apply_settings(8'd3, 10'd7, 8'sh80, 6'd2);
        send_event(CMD_PACKET, -8'sd42, 4'd9);
        send_event(CMD_SCAN, 8'sd0, 4'd0);
        send_event(CMD_SCAN, 8'sd0, 4'd0);
        send_event(CMD_SCAN, 8'sd0, 4'd0);
    endtask

    task automatic run_random_phase(input int n);
        int sel;
        logic [CMD_W-1:0] c;
        logic signed [RSSI_W-1:0] r;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            c = (sel < 30) ? CMD_PACKET :
                (sel < 52) ? CMD_SCAN :
                (sel < 95) ? CMD_TICK : CMD_UNUSED;
            if ($urandom_range(0, 99) < 80)
                r = RSSI_W'(int'($urandom_range(0, 75)) - 95);
            else
                r = RSSI_W'($urandom);
            send_event(c, r, CHAN_W'($urandom_range(0, 15)));
        end
    endtask

    task automatic test_random();
        logic [ON_W-1:0]          on_t;
        logic [OFF_W-1:0]         off_m;
        logic signed [RSSI_W-1:0] near_t;
        logic [DECAY_W-1:0]       decay_s;
        for (int p = 0; p < 8; p++)
        begin
            on_t    = ($urandom_range(0, 3) == 0) ? ON_W'($urandom_range(0, 255))
                                                   : ON_W'($urandom_range(0, 12));
            off_m   = ($urandom_range(0, 3) == 0) ? OFF_W'($urandom_range(0, 1023))
                                                   : OFF_W'($urandom_range(0, 40));
            near_t  = RSSI_W'(int'($urandom_range(0, 60)) - 90);
            decay_s = DECAY_W'($urandom_range(0, 63));
            case (p)
                0: apply_settings(8'd255, 10'd1023, 8'sh80, 6'd62);
                1: apply_settings(8'd0, 10'd0, 8'sd127, 6'd0);
                2: apply_settings(8'd1, 10'd1, 8'sh80, 6'd63);
                default: apply_settings(on_t, off_m, near_t, decay_s);
            endcase
            no_idle <= (p == 3);
            run_random_phase(180);
        end
        no_idle <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic signed [10:0] expv,
                                 input logic signed [10:0] actv);
        if (actv !== expv)
        begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (status_q.size() == 0)
            begin
                $error("result transfer with no event outstanding");
                mismatches++;
            end
            else
            begin
                want = status_q.pop_front();
                results_seen++;
                compare_field("led_on", 11'(want.led_on), 11'(led_on));
                compare_field("tune_channel", 11'(want.tune_channel),
                              11'(tune_channel));
                compare_field("peak_level", 11'(want.peak_level), 11'(peak_level));
                compare_field("peak_chan", 11'(want.peak_chan), 11'(peak_chan));
                compare_field("off_ticks", 11'(want.off_ticks), 11'(off_ticks));
            end
        end
        out_ready <= no_idle || ($urandom_range(0, 99) >= 7);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        on_time_m     = ON_TIME_RST;
        off_max_m     = OFF_MAX_RST;
        near_thr_m    = NEAR_THR_RST;
        decay_steps_m = DECAY_STEPS_RST;
        peak_m        = PEAK_FLOOR;
        peak_ch_m     = '0;
        off_time_m    = OFF_MAX_RST;
        blink_m       = '0;
        led_m         = 1'b0;
        hop_m         = HOP_FIRST;
        decay_cnt_m   = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_ladder();
        test_blink();
        test_zero_and_off_max();
        test_random();

        wait_drain();
        repeat (4) @(posedge clk);
        $display("Covered %0d packets, %0d scan steps, %0d ticks and %0d unused commands",
                 events_by_cmd[CMD_PACKET], events_by_cmd[CMD_SCAN],
                 events_by_cmd[CMD_TICK], events_by_cmd[CMD_UNUSED]);
        $display("over %0d register settings; %0d results compared, %0d blink restarts",
                 settings_used, results_seen, blink_restarts);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/rpbi_pkg.sv
rtl/rpbi_core.sv
rtl/rssi_peak_blink_indicator_top.sv
verif/tb_rssi_peak_blink_indicator_top.sv
